/* src/biquad_iir_filter_assert.svh */
// Assertion macros for the biquad IIR filter checker.
// No dependencies; included by the checker file.
`ifndef BIQUAD_IIR_FILTER_ASSERT_SVH
`define BIQUAD_IIR_FILTER_ASSERT_SVH

// Checked outside reset.
`define BIQ_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("biquad assertion failed");

// Checked at every edge, reset included.
`define BIQ_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("biquad assertion failed");

`endif

/* src/biq_pkg.sv */
// Shared constants and types for the biquad IIR filter.
// No dependencies; used by biq_mac, biquad_iir_filter, biq_checker and tb_top.
package biq_pkg;

   localparam int SAMPLE_BITS_DEF = 16;
   localparam int COEF_BITS_DEF   = 20;
   localparam int COEF_FRAC       = 16;
   localparam int STATE_W         = 40;
   localparam int NUM_REGS        = 5;
   localparam int CSR_IDX_W       = 3;

   localparam logic [CSR_IDX_W-1:0] REG_B0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_B1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_B2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_A1 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_A2 = 3'd4;

   typedef struct packed {
      logic mul_en;
      logic acc_en;
      logic a_from_acc;
      logic b_round;
      logic sub;
   } mac_ctrl_type;

endpackage

/* src/biq_mac.sv */
// Shared multiplier and accumulator for the biquad filter, with output and state saturation.
// Depends on biq_pkg.
module biq_mac #(
   parameter int SAMPLE_BITS = biq_pkg::SAMPLE_BITS_DEF,
   parameter int COEF_BITS   = biq_pkg::COEF_BITS_DEF
) (
   input  logic                             clock,
   input  biq_pkg::mac_ctrl_type            ctrl,
   input  logic signed [COEF_BITS-1:0]      mul_coef,
   input  logic signed [SAMPLE_BITS-1:0]    mul_sample,
   input  logic signed [biq_pkg::STATE_W-1:0] st_opnd,
   output logic signed [SAMPLE_BITS-1:0]    y_sat,
   output logic                             y_clip,
   output logic signed [biq_pkg::STATE_W-1:0] state_sat
);

   localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
   localparam int ACC_W  = ((PROD_W > biq_pkg::STATE_W) ? PROD_W : biq_pkg::STATE_W) + 2;
   localparam int SH_W   = ACC_W - biq_pkg::COEF_FRAC;
   localparam int SW     = biq_pkg::STATE_W;
   localparam logic [ACC_W-1:0] RND = ACC_W'(1) << (biq_pkg::COEF_FRAC - 1);

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic [ACC_W-1:0]         add_a, add_b;
   logic [SH_W-1:0]          shifted;
   logic [SH_W-SAMPLE_BITS:0] y_top;
   logic [ACC_W-SW:0]        s_top;
   logic                     y_fits, s_fits;

   assign prod_in = mul_coef * mul_sample;

   always_comb begin
      add_a = ctrl.a_from_acc ? acc_ff : {{(ACC_W-SW){st_opnd[SW-1]}}, st_opnd};
      add_b = ctrl.b_round ? RND : {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      acc_in = ctrl.sub ? $signed(add_a - add_b) : $signed(add_a + add_b);
   end

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= prod_in;
      end
      if (ctrl.acc_en) begin
         acc_ff <= acc_in;
      end
   end

   // round half up, then clamp to the sample range
   always_comb begin
      shifted = acc_ff[ACC_W-1:biq_pkg::COEF_FRAC];
      y_top   = shifted[SH_W-1:SAMPLE_BITS-1];
      y_fits  = (&y_top) | ~(|y_top);
      y_clip  = ~y_fits;
      y_sat   = y_fits ? shifted[SAMPLE_BITS-1:0]
                       : {shifted[SH_W-1], {(SAMPLE_BITS-1){~shifted[SH_W-1]}}};
      s_top   = acc_ff[ACC_W-1:SW-1];
      s_fits  = (&s_top) | ~(|s_top);
      state_sat = s_fits ? acc_ff[SW-1:0] : {acc_ff[ACC_W-1], {(SW-1){~acc_ff[ACC_W-1]}}};
   end

endmodule

/* src/biquad_iir_filter.sv */
// Biquad IIR section, transposed direct form II, fixed point.
// Depends on biq_pkg and biq_mac.
//
// Channels: req_ carries one signed sample word, rsp_ carries the filtered word
// and a clip flag, csr_ writes coefficient registers b0, b1, b2, a1, a2
// (index 0..4, Q.16 signed, already normalized by a0; other indexes ignored).
// csr_ready is always high; write coefficients only while the filter is idle.
// Each sample runs through one shared multiplier and one accumulator under a
// sequencer (MB0, AB0, YQ, MA1, SA1, WS0, SA2, WS1); a new word is taken only
// in idle, after the last step. The result is registered onto rsp_ on leaving WS1.
// y = round(b0*x + s0), saturated to the sample width; clipped marks saturation.
// States s0, s1 are 40-bit and saturate.
// The output register holds a result until taken; the next sample is still
// accepted and computed, and the sequence waits in its last step if the
// previous word has not been taken.
// Reset: delay states cleared, b0 = 1.0, other coefficients 0, rsp_valid low.
module biquad_iir_filter #(
   parameter int SAMPLE_BITS = biq_pkg::SAMPLE_BITS_DEF,
   parameter int COEF_BITS   = biq_pkg::COEF_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [SAMPLE_BITS-1:0]         req_sample_in,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]         rsp_filtered_sample,
   output logic                                  rsp_clipped,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [biq_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [COEF_BITS-1:0]                  csr_wdata
);

   localparam int SW = biq_pkg::STATE_W;
   localparam longint unsigned B0_ONE = 64'd1 << biq_pkg::COEF_FRAC;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_MB0  = 4'd1;
   localparam logic [3:0] ST_AB0  = 4'd2;
   localparam logic [3:0] ST_YQ   = 4'd3;
   localparam logic [3:0] ST_MA1  = 4'd4;
   localparam logic [3:0] ST_SA1  = 4'd5;
   localparam logic [3:0] ST_WS0  = 4'd6;
   localparam logic [3:0] ST_SA2  = 4'd7;
   localparam logic [3:0] ST_WS1  = 4'd8;

   logic [3:0]                       state_ff, state_in;
   logic [COEF_BITS-1:0]             coef_ff [biq_pkg::NUM_REGS];
   logic signed [SAMPLE_BITS-1:0]    x_ff, y_ff;
   logic                             clip_ff;
   logic signed [SW-1:0]             s0_ff, s1_ff;
   logic                             rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0]    rsp_sample_ff;
   logic                             rsp_clip_ff;

   biq_pkg::mac_ctrl_type            ctrl;
   logic [biq_pkg::CSR_IDX_W-1:0]    coef_sel;
   logic                             use_y;
   logic signed [SW-1:0]             st_opnd;
   logic signed [SAMPLE_BITS-1:0]    y_sat;
   logic                             y_clip;
   logic signed [SW-1:0]             state_sat;
   logic                             out_free;

   assign req_ready           = (state_ff == ST_IDLE);
   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_filtered_sample = rsp_sample_ff;
   assign rsp_clipped         = rsp_clip_ff;
   assign out_free            = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      ctrl     = '0;
      coef_sel = biq_pkg::REG_B0;
      use_y    = 1'b0;
      st_opnd  = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_MB0;
         end
         ST_MB0: begin
            ctrl.mul_en  = 1'b1;
            ctrl.acc_en  = 1'b1;
            ctrl.b_round = 1'b1;
            st_opnd      = s0_ff;
            state_in     = ST_AB0;
         end
         ST_AB0: begin
            ctrl.mul_en     = 1'b1;
            coef_sel        = biq_pkg::REG_B1;
            ctrl.acc_en     = 1'b1;
            ctrl.a_from_acc = 1'b1;
            state_in        = ST_YQ;
         end
         ST_YQ: begin
            ctrl.acc_en = 1'b1;
            st_opnd     = s1_ff;
            state_in    = ST_MA1;
         end
         ST_MA1: begin
            ctrl.mul_en = 1'b1;
            coef_sel    = biq_pkg::REG_A1;
            use_y       = 1'b1;
            state_in    = ST_SA1;
         end
         ST_SA1: begin
            ctrl.mul_en     = 1'b1;
            coef_sel        = biq_pkg::REG_B2;
            ctrl.acc_en     = 1'b1;
            ctrl.a_from_acc = 1'b1;
            ctrl.sub        = 1'b1;
            state_in        = ST_WS0;
         end
         ST_WS0: begin
            ctrl.mul_en = 1'b1;
            coef_sel    = biq_pkg::REG_A2;
            use_y       = 1'b1;
            ctrl.acc_en = 1'b1;
            state_in    = ST_SA2;
         end
         ST_SA2: begin
            ctrl.acc_en     = 1'b1;
            ctrl.a_from_acc = 1'b1;
            ctrl.sub        = 1'b1;
            state_in        = ST_WS1;
         end
         ST_WS1: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   biq_mac #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS)
   ) u_mac (
      .clock      (clock),
      .ctrl       (ctrl),
      .mul_coef   ($signed(coef_ff[coef_sel])),
      .mul_sample (use_y ? y_ff : x_ff),
      .st_opnd    (st_opnd),
      .y_sat      (y_sat),
      .y_clip     (y_clip),
      .state_sat  (state_sat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         s0_ff        <= '0;
         s1_ff        <= '0;
         coef_ff[biq_pkg::REG_B0] <= B0_ONE[COEF_BITS-1:0];
         coef_ff[biq_pkg::REG_B1] <= '0;
         coef_ff[biq_pkg::REG_B2] <= '0;
         coef_ff[biq_pkg::REG_A1] <= '0;
         coef_ff[biq_pkg::REG_A2] <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_index < biq_pkg::CSR_IDX_W'(biq_pkg::NUM_REGS)) begin
            coef_ff[csr_index] <= csr_wdata;
         end
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == ST_WS0) begin
            s0_ff <= state_sat;
         end
         if (state_ff == ST_WS1 && out_free) begin
            s1_ff        <= state_sat;
            rsp_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         x_ff <= req_sample_in;
      end
      if (state_ff == ST_YQ) begin
         y_ff    <= y_sat;
         clip_ff <= y_clip;
      end
      if (state_ff == ST_WS1 && out_free) begin
         rsp_sample_ff <= y_ff;
         rsp_clip_ff   <= clip_ff;
      end
   end

endmodule

/* src/biq_checker.sv */
// Port-level checker for biquad_iir_filter, attached by bind.
// Depends on biquad_iir_filter_assert.svh and biq_pkg.
`include "biquad_iir_filter_assert.svh"

module biq_checker #(
   parameter int SAMPLE_BITS = biq_pkg::SAMPLE_BITS_DEF
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [SAMPLE_BITS-1:0] rsp_filtered_sample,
   input logic                   rsp_clipped
);

   logic at_rail;

   assign at_rail =
      (&rsp_filtered_sample[SAMPLE_BITS-2:0] && !rsp_filtered_sample[SAMPLE_BITS-1]) ||
      (~|rsp_filtered_sample[SAMPLE_BITS-2:0] && rsp_filtered_sample[SAMPLE_BITS-1]);

   `BIQ_ASSERT_ALWAYS(a_reset_state, clock, reset |=> (!rsp_valid && req_ready))
   `BIQ_ASSERT(a_busy_after_accept, clock, reset, (req_valid && req_ready) |=> !req_ready)
   `BIQ_ASSERT(a_clip_at_rail, clock, reset, (rsp_valid && rsp_clipped) |-> at_rail)
   `BIQ_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_filtered_sample) && $stable(rsp_clipped)))

endmodule

bind biquad_iir_filter biq_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_biq_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_ready           (req_ready),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_filtered_sample (rsp_filtered_sample),
   .rsp_clipped         (rsp_clipped)
);

/* sim/tb_top.sv */
// Self-checking bench for biquad_iir_filter: streams samples through the filter
// under random stalls and checks every output word against a built-in model.
// Depends on biq_pkg and the filter RTL.
`timescale 1ns / 100ps

module tb_top;

   import biq_pkg::*;

   localparam int SAMPLE_BITS  = SAMPLE_BITS_DEF;
   localparam int COEF_BITS    = COEF_BITS_DEF;
   localparam int HALF_PERIOD  = 6;
   localparam int LIMIT_CYCLES = 400_000;
   localparam int TAIL_CYCLES  = 30;
   localparam int RANDOM_ITEMS = 1000;
   localparam int MAX_REPORTS  = 10;

   typedef logic signed [SAMPLE_BITS-1:0] sample_t;
   typedef logic signed [COEF_BITS-1:0]   coef_t;
   typedef logic signed [STATE_W-1:0]     state_t;
   typedef logic [CSR_IDX_W-1:0]          csr_idx_t;
   typedef coef_t coef_set_t [NUM_REGS];

   typedef struct {
      sample_t filtered;
      logic    clipped;
   } out_word_t;

   localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam coef_t   COEF_MAX   = {1'b0, {(COEF_BITS-1){1'b1}}};
   localparam coef_t   COEF_MIN   = {1'b1, {(COEF_BITS-1){1'b0}}};
   localparam coef_t   UNITY      = coef_t'(1 << COEF_FRAC);
   localparam coef_t   HALF_GAIN  = coef_t'(1 << (COEF_FRAC - 1));
   localparam longint  ROUND_HALF = longint'(1) <<< (COEF_FRAC - 1);
   localparam longint  STATE_HI   = (longint'(1) <<< (STATE_W - 1)) - 1;
   localparam longint  STATE_LO   = -STATE_HI - 1;
   localparam int      SPARE_IDX  = (1 << CSR_IDX_W) - 1 - NUM_REGS;

   // Filter model plus the queue of output words still owed by the DUT.
   class biquad_tracker;
      coef_t       coefs[NUM_REGS];
      state_t      first_delay;
      state_t      second_delay;
      out_word_t   owed_words[$];
      int unsigned words_checked;
      int unsigned mismatches;

      function new();
         foreach (coefs[i]) coefs[i] = '0;
         coefs[REG_B0] = UNITY;
         first_delay   = '0;
         second_delay  = '0;
         words_checked = 0;
         mismatches    = 0;
      endfunction

      function void write_coef(csr_idx_t idx, coef_t data);
         if (idx < NUM_REGS) coefs[idx] = data;
      endfunction

      function state_t clamp_state(longint v);
         if (v > STATE_HI) return state_t'(STATE_HI);
         if (v < STATE_LO) return state_t'(STATE_LO);
         return state_t'(v);
      endfunction

      function void take_sample(sample_t x);
         longint    xs;
         longint    acc;
         longint    y;
         out_word_t w;
         xs  = longint'(x);
         acc = longint'(coefs[REG_B0]) * xs + longint'(first_delay) + ROUND_HALF;
         y   = acc >>> COEF_FRAC;
         w.clipped = 1'b0;
         if (y > longint'(SAMPLE_MAX)) begin
            y = longint'(SAMPLE_MAX);
            w.clipped = 1'b1;
         end else if (y < longint'(SAMPLE_MIN)) begin
            y = longint'(SAMPLE_MIN);
            w.clipped = 1'b1;
         end
         w.filtered = sample_t'(y);
         // feedback uses the word actually sent out
         first_delay  = clamp_state(longint'(second_delay) + longint'(coefs[REG_B1]) * xs
                                    - longint'(coefs[REG_A1]) * y);
         second_delay = clamp_state(longint'(coefs[REG_B2]) * xs
                                    - longint'(coefs[REG_A2]) * y);
         owed_words.push_back(w);
      endfunction

      function void check_output(sample_t filtered, logic clipped);
         out_word_t w;
         words_checked++;
         if (owed_words.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("word %0d: unexpected output %0d clipped %0b",
                        words_checked, filtered, clipped);
            return;
         end
         w = owed_words.pop_front();
         if (filtered !== w.filtered || clipped !== w.clipped) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("word %0d: filtered exp %0d got %0d, clipped exp %0b got %0b",
                        words_checked, w.filtered, filtered, w.clipped, clipped);
         end
      endfunction
   endclass

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_ready;
   sample_t  req_sample_in = '0;
   logic     rsp_valid;
   logic     rsp_ready = 1'b0;
   sample_t  rsp_filtered_sample;
   logic     rsp_clipped;
   logic     csr_valid = 1'b0;
   logic     csr_ready;
   csr_idx_t csr_index = '0;
   coef_t    csr_wdata = '0;

   biquad_iir_filter #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .COEF_BITS  (COEF_BITS)
   ) DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_sample_in      (req_sample_in),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_filtered_sample(rsp_filtered_sample),
      .rsp_clipped        (rsp_clipped),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   biquad_tracker tracker = new();
   bit            calm = 1'b0;
   int unsigned   samples_sent = 0;

   always begin
      #(HALF_PERIOD) clock = 1'b1;
      #(HALF_PERIOD) clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.check_output(rsp_filtered_sample, rsp_clipped);
      rsp_ready <= calm || ($urandom_range(0, 99) >= 25);
   end

   initial begin
      #(LIMIT_CYCLES * 2 * HALF_PERIOD);
      $display("tb_top NOT OK");
      $finish;
   end

   task automatic send_sample(input sample_t x);
      if (!calm && $urandom_range(0, 99) < 25) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= x;
      do @(posedge clock); while (!req_ready);
      tracker.take_sample(x);
      samples_sent++;
   endtask

   // stop sending and wait for every owed word
   task automatic drain_outputs();
      req_valid <= 1'b0;
      while (tracker.owed_words.size() != 0) @(posedge clock);
   endtask

   task automatic write_coef(input csr_idx_t idx, input coef_t data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      tracker.write_coef(idx, data);
   endtask

   task automatic load_coefs(input coef_set_t c, input bit spare_writes);
      for (int i = 0; i < NUM_REGS; i++) begin
         if (spare_writes && $urandom_range(0, 1))
            write_coef(csr_idx_t'(NUM_REGS + $urandom_range(0, SPARE_IDX)),
                       coef_t'($urandom()));
         write_coef(csr_idx_t'(i), c[i]);
      end
      if (spare_writes)
         write_coef(csr_idx_t'(NUM_REGS + $urandom_range(0, SPARE_IDX)),
                    coef_t'($urandom()));
      csr_valid <= 1'b0;
   endtask

   task automatic pick_coefs(output coef_set_t c);
      int unsigned kind;
      int          a2;
      kind = $urandom_range(0, 3);
      for (int i = 0; i < NUM_REGS; i++) begin
         case (kind)
            0: c[i] = coef_t'($urandom());
            1: c[i] = coef_t'($urandom_range(0, 2 * 65536) - 65536);
            2: begin
               case ($urandom_range(0, 4))
                  0: c[i] = COEF_MAX;
                  1: c[i] = COEF_MIN;
                  2: c[i] = UNITY;
                  3: c[i] = -UNITY;
                  default: c[i] = '0;
               endcase
            end
            default: c[i] = coef_t'($urandom_range(0, 510) - 255);
         endcase
      end
      if (kind == 1) begin
         // keep the poles inside the unit circle
         a2 = $urandom_range(0, 58982);
         c[REG_A2] = coef_t'(a2);
         c[REG_A1] = coef_t'($urandom_range(0, 2 * (65535 + a2)) - (65535 + a2));
      end
   endtask

   function automatic sample_t pick_sample(sample_t last);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 15) return last;
      if (roll < 30) begin
         case ($urandom_range(0, 4))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return sample_t'(1);
            3: return sample_t'(-1);
            default: return '0;
         endcase
      end
      if (roll < 45) return sample_t'($urandom_range(0, 600) - 300);
      return sample_t'($urandom());
   endfunction

   initial begin
      coef_set_t cset;
      sample_t   last;
      int        phase_len;
      last = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset coefficients: straight pass-through
      send_sample('0);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(sample_t'(1));
      send_sample(sample_t'(-1));
      drain_outputs();

      // largest gain: clips both ways, and just over full scale
      cset = '{COEF_MAX, '0, '0, '0, '0};
      load_coefs(cset, 1'b0);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(sample_t'(4096));
      drain_outputs();

      // half gain: round half up on both signs
      cset = '{HALF_GAIN, '0, '0, '0, '0};
      load_coefs(cset, 1'b0);
      send_sample(sample_t'(1));
      send_sample(sample_t'(-1));
      send_sample(sample_t'(-3));
      send_sample(sample_t'(3));
      drain_outputs();

      // extreme taps and feedback, with writes to unmapped indexes
      cset = '{UNITY, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX};
      load_coefs(cset, 1'b1);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample('0);
      send_sample('0);
      send_sample(sample_t'(12345));
      send_sample('0);
      drain_outputs();

      while (samples_sent < RANDOM_ITEMS) begin
         pick_coefs(cset);
         load_coefs(cset, $urandom_range(0, 2) == 0);
         phase_len = $urandom_range(20, 120);
         for (int n = 0; n < phase_len; n++) begin
            calm = (samples_sent >= 400 && samples_sent < 600);
            last = pick_sample(last);
            send_sample(last);
         end
         drain_outputs();
      end
      calm = 1'b0;

      repeat (TAIL_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.owed_words.size() == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule
